>>> hdl/dptv_pkg.sv
// shared constants and types for the device path node-chain validator
package dptv_pkg;

   localparam int unsigned MAX_PATH_BYTES = 65536;
   localparam int unsigned HEADER_BYTES = 4;

   localparam int unsigned SIZE_W = 17;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W = 17;

   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIZE_LIMIT = 8'd0,
      CSR_END_TYPE   = 8'd1,
      CSR_TERM_SUB   = 8'd2,
      CSR_SEP_SUB    = 8'd3
   } csr_index_type;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_COMPROMISED = 1'b1;

   localparam size_type LIMIT_MIN = size_type'(HEADER_BYTES);
   localparam size_type LIMIT_MAX = size_type'(MAX_PATH_BYTES);

   localparam len_type HEADER_LEN = len_type'(HEADER_BYTES);
   localparam size_type HEADER_SIZE = size_type'(HEADER_BYTES);

   localparam size_type SIZE_LIMIT_RESET = size_type'(65536);
   localparam byte_type END_TYPE_RESET = 8'd127;
   localparam byte_type TERM_SUB_RESET = 8'd255;
   localparam byte_type SEP_SUB_RESET = 8'd1;

endpackage

>>> hdl/dptv_if.sv
// request, response and register write channels of the validator

interface dptv_req_if;
   logic              valid;
   logic              ready;
   dptv_pkg::byte_type data_byte;
   logic              path_start;

   modport source (output valid, data_byte, path_start, input ready);
   modport sink (input valid, data_byte, path_start, output ready);
endinterface

interface dptv_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   dptv_pkg::size_type total_size;
   logic               multi_instance;

   modport source (output valid, status, total_size, multi_instance, input ready);
   modport sink (input valid, status, total_size, multi_instance, output ready);
endinterface

interface dptv_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [dptv_pkg::CSR_INDEX_W-1:0]       index;
   logic [dptv_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/device_path_tlv_validator_top.sv
// Device path node-chain validator: takes one path byte per request and walks the
// chain of type/subtype/length nodes, giving at most one response per path. Each
// request is captured in an input register, checked against the walk state (node
// offset, length, bytes used, limit) once the output register is free, and any
// result lands in an output register; one request is taken every cycle unless a
// response waits untaken and the input register is full. The input register lets
// a new request in while a response waits to be taken. Register writes are always
// ready; the size limit is clamped to 4..65536 when written.
module device_path_tlv_validator_top (
   input  logic             clock,
   input  logic             reset,
   dptv_req_if.sink         req_chan,
   dptv_rsp_if.source       rsp_chan,
   dptv_csr_if.sink         csr_chan
);

   // configuration
   dptv_pkg::size_type limit_ff, limit_in;
   dptv_pkg::byte_type end_type_ff, term_sub_ff, sep_sub_ff;

   // input stage
   logic               in_valid_ff, in_valid_in;
   dptv_pkg::byte_type in_byte_ff;
   logic               in_start_ff;

   // walk state
   dptv_pkg::size_type bytes_used_ff, bytes_used_in;
   dptv_pkg::len_type  offset_ff, offset_in;
   dptv_pkg::len_type  node_len_ff, node_len_in;
   dptv_pkg::byte_type node_type_ff, node_type_in;
   dptv_pkg::byte_type node_sub_ff, node_sub_in;
   logic               saw_inst_ff, saw_inst_in;
   logic               done_ff, done_in;

   // output stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic               status_ff, status_in;
   dptv_pkg::size_type total_size_ff, total_size_in;
   logic               multi_ff, multi_in;

   logic               advance;
   logic               req_accept;
   logic               res_valid;
   logic               complete;
   dptv_pkg::size_type bu;
   dptv_pkg::len_type  off;
   dptv_pkg::len_type  len_full;
   dptv_pkg::size_type bu_next;
   logic [dptv_pkg::SIZE_W:0] span_sum;
   logic [dptv_pkg::SIZE_W:0] room_sum;
   logic [dptv_pkg::LEN_W:0]  off_plus;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.total_size     = total_size_ff;
   assign rsp_chan.multi_instance = multi_ff;

   // clamp size limit on write
   always_comb begin
      limit_in = csr_chan.data;
      if (csr_chan.data < dptv_pkg::LIMIT_MIN) begin
         limit_in = dptv_pkg::LIMIT_MIN;
      end else if (csr_chan.data > dptv_pkg::LIMIT_MAX) begin
         limit_in = dptv_pkg::LIMIT_MAX;
      end
   end

   always_comb begin
      bu       = in_start_ff ? '0 : bytes_used_ff;
      off      = in_start_ff ? '0 : offset_ff;
      len_full = {in_byte_ff, node_len_ff[7:0]};
      span_sum = {1'b0, bu} + {2'b00, len_full};
      off_plus = {1'b0, off} + 17'd1;

      bytes_used_in = bu;
      offset_in     = off;
      node_len_in   = in_start_ff ? '0 : node_len_ff;
      node_type_in  = node_type_ff;
      node_sub_in   = node_sub_ff;
      saw_inst_in   = in_start_ff ? 1'b0 : saw_inst_ff;
      done_in       = in_start_ff ? 1'b0 : done_ff;

      res_valid     = 1'b0;
      status_in     = dptv_pkg::STATUS_COMPROMISED;
      total_size_in = '0;
      multi_in      = 1'b0;
      complete      = 1'b0;
      bu_next       = bu;
      room_sum      = '0;

      if (!done_in) begin
         unique case (off)
            16'd0: node_type_in = in_byte_ff;
            16'd1: node_sub_in  = in_byte_ff;
            16'd2: node_len_in  = {8'd0, in_byte_ff};
            16'd3: begin
               node_len_in = len_full;
               if (len_full < dptv_pkg::HEADER_LEN || span_sum > {1'b0, limit_ff}) begin
                  res_valid = 1'b1;
                  done_in   = 1'b1;
               end else if (len_full == dptv_pkg::HEADER_LEN) begin
                  complete = 1'b1;
               end
            end
            default: begin
               if (off_plus >= {1'b0, node_len_in}) begin
                  complete = 1'b1;
               end
            end
         endcase

         if (!res_valid) begin
            if (!complete) begin
               offset_in = off_plus[dptv_pkg::LEN_W-1:0];
            end else begin
               bu_next       = bu + dptv_pkg::size_type'(node_len_in);
               bytes_used_in = bu_next;
               offset_in     = '0;
               room_sum      = {1'b0, bu_next} + {1'b0, dptv_pkg::HEADER_SIZE};
               if (node_type_in == end_type_ff && node_sub_in == term_sub_ff) begin
                  res_valid     = 1'b1;
                  done_in       = 1'b1;
                  status_in     = dptv_pkg::STATUS_OK;
                  total_size_in = bu_next;
                  multi_in      = saw_inst_in;
               end else begin
                  if (node_type_in == end_type_ff && node_sub_in == sep_sub_ff) begin
                     saw_inst_in = 1'b1;
                  end
                  if (room_sum > {1'b0, limit_ff}) begin
                     res_valid = 1'b1;
                     done_in   = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid_in = (advance && res_valid) || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= dptv_pkg::SIZE_LIMIT_RESET;
         end_type_ff   <= dptv_pkg::END_TYPE_RESET;
         term_sub_ff   <= dptv_pkg::TERM_SUB_RESET;
         sep_sub_ff    <= dptv_pkg::SEP_SUB_RESET;
         in_valid_ff   <= 1'b0;
         bytes_used_ff <= '0;
         offset_ff     <= '0;
         node_len_ff   <= '0;
         node_type_ff  <= '0;
         node_sub_ff   <= '0;
         saw_inst_ff   <= 1'b0;
         done_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               dptv_pkg::CSR_SIZE_LIMIT: limit_ff    <= limit_in;
               dptv_pkg::CSR_END_TYPE:   end_type_ff <= csr_chan.data[7:0];
               dptv_pkg::CSR_TERM_SUB:   term_sub_ff <= csr_chan.data[7:0];
               dptv_pkg::CSR_SEP_SUB:    sep_sub_ff  <= csr_chan.data[7:0];
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            bytes_used_ff <= bytes_used_in;
            offset_ff     <= offset_in;
            node_len_ff   <= node_len_in;
            node_type_ff  <= node_type_in;
            node_sub_ff   <= node_sub_in;
            saw_inst_ff   <= saw_inst_in;
            done_ff       <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_chan.data_byte;
         in_start_ff <= req_chan.path_start;
      end
      if (advance && res_valid) begin
         status_ff     <= status_in;
         total_size_ff <= total_size_in;
         multi_ff      <= multi_in;
      end
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the device path node-chain validator with a node-walk scoreboard

typedef struct {
   logic               status;
   dptv_pkg::size_type total_size;
   logic               multi_instance;
} walk_result_type;

class node_walk_scoreboard;
   dptv_pkg::size_type limit_reg;
   dptv_pkg::byte_type end_type;
   dptv_pkg::byte_type term_sub;
   dptv_pkg::byte_type sep_sub;

   dptv_pkg::size_type bytes_used;
   dptv_pkg::len_type  node_offset;
   dptv_pkg::len_type  node_len;
   dptv_pkg::byte_type node_type;
   dptv_pkg::byte_type node_subtype;
   bit                 saw_instance;
   bit                 walk_done;

   walk_result_type expected_results[$];
   int unsigned     mismatches;
   int unsigned     checked;

   function new();
      limit_reg = dptv_pkg::SIZE_LIMIT_RESET;
      end_type = dptv_pkg::END_TYPE_RESET;
      term_sub = dptv_pkg::TERM_SUB_RESET;
      sep_sub = dptv_pkg::SEP_SUB_RESET;
      bytes_used = '0;
      node_offset = '0;
      node_len = '0;
      node_type = '0;
      node_subtype = '0;
      saw_instance = 1'b0;
      walk_done = 1'b1;
      mismatches = 0;
      checked = 0;
   endfunction

   function void write_reg(dptv_pkg::csr_index_type idx, dptv_pkg::size_type val);
      case (idx)
         dptv_pkg::CSR_SIZE_LIMIT: limit_reg = val;
         dptv_pkg::CSR_END_TYPE: end_type = val[7:0];
         dptv_pkg::CSR_TERM_SUB: term_sub = val[7:0];
         dptv_pkg::CSR_SEP_SUB: sep_sub = val[7:0];
         default: ;
      endcase
   endfunction

   function void push_result(logic st, dptv_pkg::size_type sz, logic mi);
      walk_result_type r;
      r.status = st;
      r.total_size = sz;
      r.multi_instance = mi;
      expected_results.push_back(r);
      walk_done = 1'b1;
   endfunction

   // returns 1 when the byte was consumed by a walk
   function bit note_byte(dptv_pkg::byte_type b, logic start);
      int unsigned lim;
      bit complete;
      complete = 1'b0;
      if (start) begin
         bytes_used = '0;
         node_offset = '0;
         node_len = '0;
         saw_instance = 1'b0;
         walk_done = 1'b0;
      end
      if (walk_done) return 1'b0;
      lim = 32'(limit_reg);
      if (lim < dptv_pkg::HEADER_BYTES) lim = dptv_pkg::HEADER_BYTES;
      if (lim > dptv_pkg::MAX_PATH_BYTES) lim = dptv_pkg::MAX_PATH_BYTES;

      if (node_offset == 0) begin
         node_type = b;
      end else if (node_offset == 1) begin
         node_subtype = b;
      end else if (node_offset == 2) begin
         node_len = dptv_pkg::len_type'(b);
      end else if (node_offset == 3) begin
         node_len[15:8] = b;
         if (32'(node_len) < dptv_pkg::HEADER_BYTES ||
             32'(bytes_used) + 32'(node_len) > lim) begin
            push_result(dptv_pkg::STATUS_COMPROMISED, '0, 1'b0);
            return 1'b1;
         end
         if (32'(node_len) == dptv_pkg::HEADER_BYTES) complete = 1'b1;
      end else if (32'(node_offset) + 1 >= 32'(node_len)) begin
         complete = 1'b1;
      end

      if (!complete) begin
         node_offset = node_offset + 1'b1;
         return 1'b1;
      end

      bytes_used = bytes_used + dptv_pkg::size_type'(node_len);
      node_offset = '0;
      if (node_type == end_type) begin
         if (node_subtype == term_sub) begin
            push_result(dptv_pkg::STATUS_OK, bytes_used, saw_instance);
            return 1'b1;
         end
         if (node_subtype == sep_sub) saw_instance = 1'b1;
      end
      if (32'(bytes_used) + dptv_pkg::HEADER_BYTES > lim)
         push_result(dptv_pkg::STATUS_COMPROMISED, '0, 1'b0);
      return 1'b1;
   endfunction

   function void check_result(logic st, dptv_pkg::size_type sz, logic mi);
      walk_result_type exp_r;
      if (expected_results.size() == 0) begin
         mismatches++;
         $display("%0t: response with none expected: status %0b size %0d multi %0b",
                  $time, st, sz, mi);
         return;
      end
      exp_r = expected_results.pop_front();
      checked++;
      if (st !== exp_r.status) begin
         mismatches++;
         $display("%0t: status expected %0b actual %0b", $time, exp_r.status, st);
      end
      if (sz !== exp_r.total_size) begin
         mismatches++;
         $display("%0t: total_size expected %0d actual %0d", $time, exp_r.total_size, sz);
      end
      if (mi !== exp_r.multi_instance) begin
         mismatches++;
         $display("%0t: multi_instance expected %0b actual %0b",
                  $time, exp_r.multi_instance, mi);
      end
   endfunction

   function int unsigned pending();
      return expected_results.size();
   endfunction
endclass

module tb;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct {
      dptv_pkg::byte_type data;
      logic               start;
   } path_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dptv_req_if req_bus();
   dptv_rsp_if rsp_bus();
   dptv_csr_if csr_bus();

   node_walk_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned live_bytes = 0;
   int unsigned phase_count = 0;
   int unsigned settings_count = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_count = 0;

   device_path_tlv_validator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result(rsp_bus.status, rsp_bus.total_size, rsp_bus.multi_instance);
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_count = $urandom_range(20, 80);
         end
         stall_count--;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= (cycle_count % 4 == 3);
            default: rsp_bus.ready <= (cycle_count % 8 < 5);
         endcase
      end
   end

   task automatic send_byte(dptv_pkg::byte_type b, logic start);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.path_start <= start;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (sb.note_byte(b, start)) live_bytes++;
   endtask

   task automatic send_path(path_byte_type q[$]);
      foreach (q[i]) send_byte(q[i].data, q[i].start);
   endtask

   task automatic write_csr(dptv_pkg::csr_index_type idx, dptv_pkg::size_type val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.write_reg(idx, val);
   endtask

   task automatic program_regs(dptv_pkg::size_type lim, dptv_pkg::byte_type et,
                               dptv_pkg::byte_type ts, dptv_pkg::byte_type ss);
      write_csr(dptv_pkg::CSR_SIZE_LIMIT, lim);
      write_csr(dptv_pkg::CSR_END_TYPE, dptv_pkg::size_type'(et));
      write_csr(dptv_pkg::CSR_TERM_SUB, dptv_pkg::size_type'(ts));
      write_csr(dptv_pkg::CSR_SEP_SUB, dptv_pkg::size_type'(ss));
      csr_bus.valid <= 1'b0;
      settings_count++;
   endtask

   // hold requests until every response is in, then let the pipeline empty
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic void push_data(ref path_byte_type q[$], input dptv_pkg::byte_type b);
      path_byte_type p;
      p.data = b;
      p.start = 1'b0;
      q.push_back(p);
   endfunction

   function automatic void add_node(ref path_byte_type q[$], input dptv_pkg::byte_type t,
                                    input dptv_pkg::byte_type st,
                                    input int unsigned len, input int unsigned body);
      push_data(q, t);
      push_data(q, st);
      push_data(q, dptv_pkg::byte_type'(len & 32'hFF));
      push_data(q, dptv_pkg::byte_type'((len >> 8) & 32'hFF));
      repeat (body) push_data(q, dptv_pkg::byte_type'($urandom_range(0, 255)));
   endfunction

   function automatic void add_filler(ref path_byte_type q[$]);
      int unsigned len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(4, 12);
      add_node(q, dptv_pkg::byte_type'($urandom_range(0, 255)),
               dptv_pkg::byte_type'($urandom_range(0, 255)), len, len - 4);
   endfunction

   function automatic void build_wellformed(ref path_byte_type q[$]);
      int unsigned nf;
      int unsigned k;
      nf = $urandom_range(0, 4);
      repeat (nf) begin
         if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(0, 2);
            add_node(q, sb.end_type, sb.sep_sub, 4 + k, k);
         end else begin
            add_filler(q);
         end
      end
      k = $urandom_range(0, 2);
      add_node(q, sb.end_type, sb.term_sub, 4 + k, k);
   endfunction

   task automatic send_random_path();
      path_byte_type q[$];
      path_byte_type p;
      int unsigned   kind;
      int unsigned   n;
      int unsigned   cut;
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
         build_wellformed(q);
      end else if (kind < 15) begin
         n = $urandom_range(0, 2);
         repeat (n) add_filler(q);
         add_node(q, dptv_pkg::byte_type'($urandom_range(0, 255)),
                  dptv_pkg::byte_type'($urandom_range(0, 255)), $urandom_range(0, 3), 2);
      end else if (kind == 15) begin
         add_node(q, dptv_pkg::byte_type'($urandom_range(0, 255)),
                  dptv_pkg::byte_type'($urandom_range(0, 255)), $urandom_range(200, 65535), 0);
      end else if (kind < 18) begin
         build_wellformed(q);
         cut = $urandom_range(1, q.size() - 1);
         while (q.size() > cut) void'(q.pop_back());
      end else begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            p.data = dptv_pkg::byte_type'($urandom_range(0, 255));
            p.start = ($urandom_range(0, 5) == 0);
            q.push_back(p);
         end
      end
      if (kind < 18) q[0].start = 1'b1;
      send_path(q);
   endtask

   initial begin
      dptv_pkg::size_type lim_pick;
      int unsigned        phase_live;
      int unsigned        mid_point;
      bit                 paused;

      paused = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.path_start = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = dptv_pkg::CSR_SIZE_LIMIT;
      csr_bus.data = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // idle bytes before any path start
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // smallest complete path
      send_byte(8'h7F, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h00, 1'b0);
      // ignored after a result
      send_byte(8'h55, 1'b0);
      // short length
      send_byte(8'h01, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      // all-zero header
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // restart mid-walk, then instance end before end-entire
      send_byte(8'h01, 1'b1);
      send_byte(8'h02, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h00, 1'b0);
      drain_block();

      while (live_bytes < 600 && phase_count < 60) begin
         case (phase_count)
            0: program_regs(dptv_pkg::size_type'(0), dptv_pkg::END_TYPE_RESET,
                            dptv_pkg::TERM_SUB_RESET, dptv_pkg::SEP_SUB_RESET);
            1: program_regs(dptv_pkg::size_type'(131071), 8'h00, 8'h00, 8'h00);
            2: program_regs(dptv_pkg::LIMIT_MIN, 8'hFF, 8'h00, 8'hFF);
            3: program_regs(dptv_pkg::LIMIT_MAX, dptv_pkg::END_TYPE_RESET,
                            dptv_pkg::TERM_SUB_RESET, dptv_pkg::SEP_SUB_RESET);
            default: begin
               lim_pick = ($urandom_range(0, 3) == 0)
                          ? dptv_pkg::size_type'($urandom_range(0, 131071))
                          : dptv_pkg::size_type'($urandom_range(4, 120));
               if ($urandom_range(0, 1) == 0)
                  program_regs(lim_pick, dptv_pkg::END_TYPE_RESET,
                               dptv_pkg::TERM_SUB_RESET, dptv_pkg::SEP_SUB_RESET);
               else
                  program_regs(lim_pick, dptv_pkg::byte_type'($urandom_range(0, 255)),
                               dptv_pkg::byte_type'($urandom_range(0, 255)),
                               dptv_pkg::byte_type'($urandom_range(0, 255)));
            end
         endcase
         phase_live = live_bytes + 100;
         mid_point = live_bytes + 50;
         while (live_bytes < phase_live) begin
            send_random_path();
            if (phase_count == 1 && !paused && live_bytes >= mid_point) begin
               drain_block();
               paused = 1'b1;
            end
         end
         drain_block();
         phase_count++;
      end

      $display("walked %0d path bytes under %0d register settings", live_bytes, settings_count);
      $display("checked %0d responses over restarts, idle bytes, bad lengths and cut paths",
               sb.checked);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
